// ===== sv/bdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

    // ring geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 2;

    localparam logic [CNT_W-1:0]  CAPACITY_RESET = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT      = CNT_W'(DEPTH);
    localparam logic [DATA_W-1:0] EMPTY_MARK     = '1;

    // operation codes; unused codes behave as a query
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DATA
    } state_t;

    // write port request to the ring memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ring_wr_t;

    // dual read request to the ring memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] front_addr;
        logic [ADDR_W-1:0] rear_addr;
    } ring_rd_t;

endpackage

// ===== sv/bdeq_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_ring
// Ring store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bdeq_ring
    import bdeq_pkg::*;
(
    input  logic              aclk,
    input  ring_wr_t          wr,
    input  ring_rd_t          rd,
    output logic [DATA_W-1:0] front_data,
    output logic [DATA_W-1:0] rear_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // two read ports, data registered
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            front_data <= mem[rd.front_addr];
            rear_data  <= mem[rd.rear_addr];
        end
    end

endmodule

// ===== sv/bounded_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_top
// Bounded deque of signed 32-bit values held in a ring memory with a front
// index and an occupancy count; reports front, rear and flags per request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  s_       | in        | s_valid / s_ready   | s_operation, s_value
//  m_       | out       | m_valid / m_ready   | m_ok, m_front_value, m_rear_value,
//           |           |                     | m_is_empty, m_is_full, m_occupancy
//  apb      | in/out    | psel/penable/pready | paddr, pwdata, prdata (capacity)
//
// A request passes through accept with state update and ring write, read of
// the front and rear entries, then loading of the result register. The
// registered ring read after the write needs its own step; one request is in
// flight at a time. A result still waiting on m_ready holds the sequencer in
// its last state. Reset clears the front index, the count and the capacity to
// its full value; the ring contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_top
    import bdeq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic signed [DATA_W-1:0] m_front_value,
    output logic signed [DATA_W-1:0] m_rear_value,
    output logic                     m_is_empty,
    output logic                     m_is_full,
    output logic [CNT_W-1:0]         m_occupancy,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  capacity_reg;
    logic              ok_reg, ok_next;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [DATA_W-1:0] out_front_reg, out_rear_reg;
    logic              out_empty_reg, out_full_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic              cur_full, cur_empty;
    logic              accept, out_load, out_free;
    ring_wr_t          ring_wr;
    ring_rd_t          ring_rd;
    logic [DATA_W-1:0] ring_front_data, ring_rear_data;
    op_t               op;

    // configuration register, written at any address of the port
    assign pready = 1'b1;
    assign prdata = PDATA_W'(capacity_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready) begin
            capacity_reg <= pwdata[CNT_W-1:0];
        end
    end

    // effective capacity saturates at the ring depth
    assign eff_cap   = (capacity_reg > DEPTH_CNT) ? DEPTH_CNT : capacity_reg;
    assign cur_full  = (count_reg >= eff_cap);
    assign cur_empty = (count_reg == '0);

    assign op       = op_t'(s_operation);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // next index, count and write request of the accepted operation
    always_comb begin
        front_next   = front_reg;
        count_next   = count_reg;
        ok_next      = ok_reg;
        ring_wr.en   = 1'b0;
        ring_wr.addr = front_reg + count_reg[ADDR_W-1:0];
        ring_wr.data = s_value;
        if (accept) begin
            ok_next = 1'b0;
            case (op)
                OP_PUSH_FRONT: begin
                    if (!cur_full) begin
                        front_next   = front_reg - 1'b1;
                        ring_wr.addr = front_reg - 1'b1;
                        ring_wr.en   = 1'b1;
                        count_next   = count_reg + 1'b1;
                        ok_next      = 1'b1;
                    end
                end
                OP_PUSH_REAR: begin
                    if (!cur_full) begin
                        ring_wr.en = 1'b1;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (!cur_empty) begin
                        front_next = front_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                OP_POP_REAR: begin
                    if (!cur_empty) begin
                        count_next = count_reg - 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                default: begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready             = 1'b0;
        ring_rd.en          = 1'b0;
        out_load            = 1'b0;
        ring_rd.front_addr  = front_reg;
        ring_rd.rear_addr   = front_reg + count_reg[ADDR_W-1:0] - 1'b1;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_READ: begin
                ring_rd.en = 1'b1;
            end
            ST_DATA: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    bdeq_ring u_ring (
        .aclk       (aclk),
        .wr         (ring_wr),
        .rd         (ring_rd),
        .front_data (ring_front_data),
        .rear_data  (ring_rear_data)
    );

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_ok_reg    <= ok_reg;
            out_front_reg <= cur_empty ? EMPTY_MARK : ring_front_data;
            out_rear_reg  <= cur_empty ? EMPTY_MARK : ring_rear_data;
            out_empty_reg <= cur_empty;
            out_full_reg  <= cur_full;
            out_count_reg <= count_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = out_ok_reg;
    assign m_front_value = $signed(out_front_reg);
    assign m_rear_value  = $signed(out_rear_reg);
    assign m_is_empty    = out_empty_reg;
    assign m_is_full     = out_full_reg;
    assign m_occupancy   = out_count_reg;

endmodule

// ===== sv/bdeq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdeq_checker
// Port-level checks of the deque result channel and request pacing.
// ----------------------------------------------------------------------------
module bdeq_checker
    import bdeq_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_ok,
    input logic signed [DATA_W-1:0] m_front_value,
    input logic signed [DATA_W-1:0] m_rear_value,
    input logic                     m_is_empty,
    input logic [CNT_W-1:0]         m_occupancy
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_front_value)
            && $stable(m_rear_value) && $stable(m_occupancy) && $stable(m_ok))
        else $error("result changed while stalled");

    // empty flag agrees with count and marks
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_occupancy == '0))
            && (!m_is_empty || (m_front_value == -1 && m_rear_value == -1)))
        else $error("empty result inconsistent");

    // occupancy never exceeds the ring depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_occupancy <= DEPTH_CNT)
        else $error("occupancy above depth");

    // one request in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

endmodule

bind bounded_double_ended_queue_top bdeq_checker u_bdeq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ok          (m_ok),
    .m_front_value (m_front_value),
    .m_rear_value  (m_rear_value),
    .m_is_empty    (m_is_empty),
    .m_occupancy   (m_occupancy)
);
